>>> rtl/timestamp_text_to_epoch_seconds_unit_assert.svh
// Assertion macros used by the timestamp unit checker.
`ifndef TIMESTAMP_TEXT_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define TIMESTAMP_TEXT_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define TTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timestamp unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timestamp unit: next-cycle check failed");

`endif

>>> rtl/tts_pkg.sv
// Shared types, character codes and calendar tables for the timestamp unit.
package tts_pkg;

    // Parse phases, one-hot.
    typedef enum logic [15:0] {
        PH_YEAR   = 16'h0001,
        PH_DASH1  = 16'h0002,
        PH_MONTH  = 16'h0004,
        PH_DASH2  = 16'h0008,
        PH_DAY    = 16'h0010,
        PH_TEE    = 16'h0020,
        PH_HOUR   = 16'h0040,
        PH_COLON1 = 16'h0080,
        PH_MINUTE = 16'h0100,
        PH_COLON2 = 16'h0200,
        PH_SECOND = 16'h0400,
        PH_ZONE   = 16'h0800,
        PH_OFFH   = 16'h1000,
        PH_OFFSEP = 16'h2000,
        PH_OFFM   = 16'h4000,
        PH_DONE   = 16'h8000
    } tts_phase_t;

    // Character codes.
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_T_UP  = 8'd84;
    localparam logic [7:0] CH_Z_UP  = 8'd90;
    localparam logic [7:0] CH_T_LO  = 8'd116;
    localparam logic [7:0] CH_Z_LO  = 8'd122;

    // Widths of the arithmetic stages.
    localparam int DAYS_W = 23;
    localparam int TOD_W  = 20;
    localparam int SECS_W = 39;

    localparam int SECONDS_PER_DAY    = 86400;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int DAYS_PER_CENTURY   = 36524;
    localparam int DAYS_PER_YEAR      = 365;
    localparam int EPOCH_DAY_OFFSET   = 719468;

    // Raw fields of one finished stamp.
    typedef struct packed {
        logic       wellformed;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic       offset_negative;
        logic [6:0] offset_hours;
        logic [6:0] offset_minutes;
    } tts_fields_t;

    // Day count and time of day of one stamp.
    typedef struct packed {
        logic                     ok;
        logic signed [DAYS_W-1:0] days;
        logic signed [TOD_W-1:0]  tod;
    } tts_span_t;

    function automatic logic [4:0] month_length(input logic [6:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            7'd2:                     len = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before each month of a year that starts in March.
    function automatic logic [8:0] march_day_base(input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/timestamp_text_to_epoch_seconds_unit.sv
// Timestamp text to Unix seconds: top level with parser, calendar and output stages.
//
// Input channel (in_valid, in_stall, char_code, is_last): one character per item,
// is_last marks the final character of a stamp. Output channel (out_valid,
// out_stall, valid_res, epoch_seconds): one result item per stamp, on its last
// character; valid_res is 0 and epoch_seconds is 0 for a malformed stamp or an
// impossible date or time.
// Throughput: one character per cycle while in_stall is low, and a new stamp may
// start in the cycle after the previous last character.
// After the edge that accepts the last character, its result passes the capture,
// calendar and output registers in that order before out_valid rises.
// A waiting result does not block the input until the capture, calendar and output
// registers all hold an item and the receiver stalls the output; in_stall then
// holds every character, not only a last one.
// Reset clears the parse state and all stage valids; the first character after
// reset starts a new stamp. Characters after a malformed one are ignored until
// the last character of that stamp.
module timestamp_text_to_epoch_seconds_unit import tts_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               char_code,
    input  logic                     is_last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     valid_res,
    output logic signed [SECS_W-1:0] epoch_seconds
);

    logic        parse_ready, cal_ready, scale_ready;
    logic        take;
    logic        cap_valid, span_valid;
    tts_fields_t cap_fields;
    tts_span_t   span;

    // Take a character whenever the capture register can accept a finished stamp.
    assign take     = in_valid && parse_ready;
    assign in_stall = !parse_ready;

    tts_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .char_code  (char_code),
        .is_last    (is_last),
        .down_ready (cal_ready),
        .ready      (parse_ready),
        .cap_valid  (cap_valid),
        .cap_fields (cap_fields)
    );

    // Validate the date and split it into day count and time of day.
    tts_calendar u_calendar (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cap_valid),
        .fields     (cap_fields),
        .down_ready (scale_ready),
        .ready      (cal_ready),
        .span_valid (span_valid),
        .span       (span)
    );

    // Scale to seconds and hold the result until the receiver takes it.
    tts_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (span_valid),
        .span          (span),
        .out_stall     (out_stall),
        .ready         (scale_ready),
        .out_valid     (out_valid),
        .valid_res     (valid_res),
        .epoch_seconds (epoch_seconds)
    );

endmodule

>>> rtl/tts_parser.sv
// Character parser: holds the parse state and captures the fields of a finished stamp.
module tts_parser import tts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        down_ready,
    output logic        ready,
    output logic        cap_valid,
    output tts_fields_t cap_fields
);

    tts_phase_t  phase_reg, phase_next, eff_phase, phase_after;
    logic [2:0]  pos_reg, pos_next, eff_pos, pos_inc, field_len;
    logic [6:0]  hi_reg, hi_next, lo_reg, lo_next;
    logic [6:0]  month_reg, month_next, day_reg, day_next;
    logic [6:0]  hour_reg, hour_next, minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic        offneg_reg, offneg_next;
    logic [6:0]  offh_reg, offh_next, offm_reg, offm_next;
    logic        malformed_reg, malformed_next;
    logic        cap_valid_reg;
    tts_fields_t cap_reg, cap_next;
    logic        is_digit;
    logic [3:0]  digit;
    logic [6:0]  acc_cur, acc_new;

    assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit     = char_code[3:0];
    assign eff_phase = (phase_reg == PH_OFFSEP) ? PH_OFFM : phase_reg;
    assign eff_pos   = (phase_reg == PH_OFFSEP) ? 3'd0 : pos_reg;
    assign pos_inc   = eff_pos + 3'd1;
    assign acc_new   = 7'(acc_cur * 7'd10) + {3'b000, digit};

    // Field under accumulation and where it leads.
    always_comb
    begin
        acc_cur     = '0;
        phase_after = PH_DONE;
        field_len   = 3'd2;
        unique case (eff_phase) inside
            PH_YEAR:
            begin
                acc_cur     = eff_pos[1] ? lo_reg : hi_reg;
                phase_after = PH_DASH1;
                field_len   = 3'd4;
            end
            PH_MONTH:
            begin
                acc_cur     = month_reg;
                phase_after = PH_DASH2;
            end
            PH_DAY:
            begin
                acc_cur     = day_reg;
                phase_after = PH_TEE;
            end
            PH_HOUR:
            begin
                acc_cur     = hour_reg;
                phase_after = PH_COLON1;
            end
            PH_MINUTE:
            begin
                acc_cur     = minute_reg;
                phase_after = PH_COLON2;
            end
            PH_SECOND:
            begin
                acc_cur     = second_reg;
                phase_after = PH_ZONE;
            end
            PH_OFFH:
            begin
                acc_cur     = offh_reg;
                phase_after = PH_OFFSEP;
            end
            PH_OFFM:
            begin
                acc_cur     = offm_reg;
                phase_after = PH_DONE;
            end
            default: ;
        endcase
    end

    // Consume one character.
    always_comb
    begin
        phase_next     = eff_phase;
        pos_next       = eff_pos;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        offneg_next    = offneg_reg;
        offh_next      = offh_reg;
        offm_next      = offm_reg;
        malformed_next = malformed_reg;
        if (malformed_reg)
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
        end
        else if (phase_reg == PH_OFFSEP && char_code == CH_COLON)
        begin
            phase_next = PH_OFFM;
            pos_next   = 3'd0;
        end
        else
        begin
            unique case (eff_phase) inside
                PH_DASH1:
                    if (char_code == CH_DASH) phase_next = PH_MONTH;
                    else malformed_next = 1'b1;
                PH_DASH2:
                    if (char_code == CH_DASH) phase_next = PH_DAY;
                    else malformed_next = 1'b1;
                PH_TEE:
                    if (char_code == CH_T_UP || char_code == CH_T_LO) phase_next = PH_HOUR;
                    else malformed_next = 1'b1;
                PH_COLON1:
                    if (char_code == CH_COLON) phase_next = PH_MINUTE;
                    else malformed_next = 1'b1;
                PH_COLON2:
                    if (char_code == CH_COLON) phase_next = PH_SECOND;
                    else malformed_next = 1'b1;
                PH_ZONE:
                begin
                    if (char_code == CH_DOT && eff_pos == 3'd0)
                        pos_next = 3'd1;
                    else if (is_digit && eff_pos == 3'd1)
                        pos_next = eff_pos;
                    else if (char_code == CH_Z_UP || char_code == CH_Z_LO)
                        phase_next = PH_DONE;
                    else if (char_code == CH_PLUS || char_code == CH_DASH)
                    begin
                        offneg_next = (char_code == CH_DASH);
                        phase_next  = PH_OFFH;
                        pos_next    = 3'd0;
                    end
                    else
                        malformed_next = 1'b1;
                end
                PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND, PH_OFFH, PH_OFFM:
                begin
                    if (is_digit)
                    begin
                        unique case (eff_phase) inside
                            PH_YEAR:
                                if (eff_pos[1]) lo_next = acc_new;
                                else hi_next = acc_new;
                            PH_MONTH:  month_next  = acc_new;
                            PH_DAY:    day_next    = acc_new;
                            PH_HOUR:   hour_next   = acc_new;
                            PH_MINUTE: minute_next = acc_new;
                            PH_SECOND: second_next = acc_new;
                            PH_OFFH:   offh_next   = acc_new;
                            default:   offm_next   = acc_new;
                        endcase
                        if (pos_inc >= field_len)
                        begin
                            phase_next = phase_after;
                            pos_next   = 3'd0;
                        end
                        else
                            pos_next = pos_inc;
                    end
                    else
                        malformed_next = 1'b1;
                end
                default: malformed_next = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        cap_next.wellformed      = !malformed_next && (phase_next == PH_DONE);
        cap_next.year_hi         = hi_next;
        cap_next.year_lo         = lo_next;
        cap_next.month           = month_next;
        cap_next.day             = day_next;
        cap_next.hour            = hour_next;
        cap_next.minute          = minute_next;
        cap_next.second          = second_next;
        cap_next.offset_negative = offneg_next;
        cap_next.offset_hours    = offh_next;
        cap_next.offset_minutes  = offm_next;
    end

    assign ready      = !cap_valid_reg || down_ready;
    assign cap_valid  = cap_valid_reg;
    assign cap_fields = cap_reg;

    // Advance parse state; drop it back to reset after the last character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_YEAR;
            pos_reg       <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            offneg_reg    <= 1'b0;
            offh_reg      <= '0;
            offm_reg      <= '0;
            malformed_reg <= 1'b0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && is_last)
            begin
                phase_reg     <= PH_YEAR;
                pos_reg       <= '0;
                hi_reg        <= '0;
                lo_reg        <= '0;
                month_reg     <= '0;
                day_reg       <= '0;
                hour_reg      <= '0;
                minute_reg    <= '0;
                second_reg    <= '0;
                offneg_reg    <= 1'b0;
                offh_reg      <= '0;
                offm_reg      <= '0;
                malformed_reg <= 1'b0;
            end
            else if (take)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                hi_reg        <= hi_next;
                lo_reg        <= lo_next;
                month_reg     <= month_next;
                day_reg       <= day_next;
                hour_reg      <= hour_next;
                minute_reg    <= minute_next;
                second_reg    <= second_next;
                offneg_reg    <= offneg_next;
                offh_reg      <= offh_next;
                offm_reg      <= offm_next;
                malformed_reg <= malformed_next;
            end
            if (ready)
                cap_valid_reg <= take && is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && take && is_last)
            cap_reg <= cap_next;
    end

endmodule

>>> rtl/tts_calendar.sv
// Calendar stage: validates the date and time and forms day count and time of day.
module tts_calendar import tts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  tts_fields_t fields,
    input  logic        down_ready,
    output logic        ready,
    output logic        span_valid,
    output tts_span_t   span
);

    logic               leap, early, lo_zero, ok;
    logic [4:0]         mlen;
    logic signed [7:0]  yhi;
    logic [6:0]         ylo, sec_c;
    logic [3:0]         idx;
    logic [8:0]         doy;
    logic signed [23:0] days_wide, base_tod, off_tod, tod_wide;
    logic               span_valid_reg;
    tts_span_t          span_reg, span_next;

    // Leap years from the century and year-in-century digit pairs.
    assign lo_zero = (fields.year_lo == 7'd0);
    assign leap    = (fields.year_lo[1:0] == 2'b00) &&
                     (!lo_zero || fields.year_hi[1:0] == 2'b00);
    assign mlen    = month_length(fields.month, leap);
    assign ok      = fields.wellformed &&
                     fields.month >= 7'd1 && fields.month <= 7'd12 &&
                     fields.day >= 7'd1 && fields.day <= {2'b00, mlen} &&
                     fields.hour <= 7'd23 && fields.minute <= 7'd59 &&
                     fields.second <= 7'd60;

    // January and February count with the previous year.
    assign early = (fields.month <= 7'd2);
    assign yhi   = (early && lo_zero) ? $signed({1'b0, fields.year_hi}) - 8'sd1
                                      : $signed({1'b0, fields.year_hi});
    assign ylo   = (early && lo_zero) ? 7'd99 : fields.year_lo - {6'd0, early};
    assign idx   = (fields.month > 7'd2) ? 4'(fields.month - 7'd3) : 4'(fields.month + 7'd9);
    assign doy   = march_day_base(idx) + {2'b00, fields.day} - 9'd1;

    assign days_wide = 24'(yhi) * 24'(DAYS_PER_CENTURY)
                     + $signed({17'd0, ylo}) * 24'(DAYS_PER_YEAR)
                     + $signed({19'd0, ylo[6:2]})
                     + 24'(yhi >>> 2)
                     + $signed({15'd0, doy})
                     - 24'(EPOCH_DAY_OFFSET);

    // Leap second 60 counts as 59.
    assign sec_c    = (fields.second > 7'd59) ? 7'd59 : fields.second;
    assign base_tod = $signed({17'd0, fields.hour}) * 24'(SECONDS_PER_HOUR)
                    + $signed({17'd0, fields.minute}) * 24'(SECONDS_PER_MINUTE)
                    + $signed({17'd0, sec_c});
    assign off_tod  = $signed({17'd0, fields.offset_hours}) * 24'(SECONDS_PER_HOUR)
                    + $signed({17'd0, fields.offset_minutes}) * 24'(SECONDS_PER_MINUTE);
    assign tod_wide = fields.offset_negative ? base_tod + off_tod : base_tod - off_tod;

    always_comb
    begin
        span_next.ok   = ok;
        span_next.days = days_wide[DAYS_W-1:0];
        span_next.tod  = tod_wide[TOD_W-1:0];
    end

    assign ready      = !span_valid_reg || down_ready;
    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_valid_reg <= 1'b0;
        else if (ready)
            span_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
            span_reg <= span_next;
    end

endmodule

>>> rtl/tts_scale.sv
// Output stage: scales days to seconds, adds time of day and holds the result.
module tts_scale import tts_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  tts_span_t                span,
    input  logic                     out_stall,
    output logic                     ready,
    output logic                     out_valid,
    output logic                     valid_res,
    output logic signed [SECS_W-1:0] epoch_seconds
);

    logic signed [40:0]       prod, total;
    logic                     out_valid_reg, ok_reg;
    logic signed [SECS_W-1:0] secs_reg, secs_next;

    assign prod      = 41'(span.days) * 41'(SECONDS_PER_DAY);
    assign total     = prod + 41'(span.tod);
    assign secs_next = span.ok ? total[SECS_W-1:0] : '0;

    assign ready         = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign valid_res     = ok_reg;
    assign epoch_seconds = secs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            ok_reg   <= span.ok;
            secs_reg <= secs_next;
        end
    end

endmodule

>>> rtl/tts_checker.sv
// Port-level checker for the timestamp unit, bound to the top level.
`include "timestamp_text_to_epoch_seconds_unit_assert.svh"

module tts_checker import tts_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     is_last,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     valid_res,
    input logic signed [SECS_W-1:0] epoch_seconds
);

    logic out_held;
    logic last_take;

    assign out_held  = out_valid && out_stall;
    assign last_take = in_valid && !in_stall && is_last;

    // Hold a stalled result item.
    `TTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)
    `TTS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(valid_res) && $stable(epoch_seconds))

    // A rejected stamp reports zero seconds.
    `TTS_ASSERT_IMPLY(a_bad_is_zero, clk, rst_n, out_valid && !valid_res, epoch_seconds == '0)

    // Input backpressure only comes from a stalled, full output.
    `TTS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // With the output flowing, a last character yields its result item on out_valid.
    `TTS_ASSERT_NEXT(a_latency, clk, rst_n, last_take ##1 !out_stall ##1 !out_stall, out_valid)

endmodule

bind timestamp_text_to_epoch_seconds_unit tts_checker u_tts_checker (.*);
